// ===== hdl/gne_pkg.sv =====
// Package for the gate netlist evaluator: field widths, gate codes, table entry layout,
// controller states and the truth-table and arity lookups.
// No dependencies.
package gne_pkg;

    localparam int MASK_W      = 64;
    localparam int OP_W        = 6;
    localparam int KIND_W      = 3;
    localparam int COUNT_W     = 7;
    localparam int BITNESS_W   = 6;
    localparam int INBITS_W    = 32;
    localparam int BITNESS_MIN = 2;
    localparam int BITNESS_MAX = 32;
    localparam logic [BITNESS_W-1:0] BITNESS_RESET = 6'd8;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_EVAL  = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_LEVEL  = 2'd2
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOT  = 3'd0,
        KIND_AND  = 3'd1,
        KIND_OR   = 3'd2,
        KIND_XOR  = 3'd3,
        KIND_NAND = 3'd4,
        KIND_NOR  = 3'd5,
        KIND_MAJ  = 3'd6
    } kind_t;

    typedef struct packed {
        logic [OP_W-1:0]   op_c;
        logic [OP_W-1:0]   op_b;
        logic [OP_W-1:0]   op_a;
        logic [KIND_W-1:0] kind;
    } gate_entry_t;

    localparam int ENTRY_W = $bits(gate_entry_t);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_GATES
    } state_t;

    function automatic logic [7:0] kind_table(input logic [KIND_W-1:0] kind);
        logic [7:0] t;
        case (kind_t'(kind))
            KIND_NOT:  t = 8'b01;
            KIND_AND:  t = 8'b1000;
            KIND_OR:   t = 8'b1110;
            KIND_XOR:  t = 8'b0110;
            KIND_NAND: t = 8'b0111;
            KIND_NOR:  t = 8'b0001;
            KIND_MAJ:  t = 8'b11101000;
            default:   t = 8'b01;
        endcase
        return t;
    endfunction

    function automatic logic [1:0] kind_arity(input logic [KIND_W-1:0] kind);
        logic [1:0] n;
        case (kind_t'(kind))
            KIND_AND, KIND_OR, KIND_XOR, KIND_NAND, KIND_NOR: n = 2'd2;
            KIND_MAJ: n = 2'd3;
            default:  n = 2'd1;
        endcase
        return n;
    endfunction

    function automatic logic [MASK_W-1:0] low_ones(input logic [COUNT_W-1:0] n);
        logic [MASK_W-1:0] m;
        for (int i = 0; i < MASK_W; i++) begin
            m[i] = (COUNT_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// ===== hdl/gne_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// No dependencies.
module gne_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/gne_gate_unit.sv =====
// One gate evaluation: gather operand bits from the slot vector and look up the truth table.
// Depends on gne_pkg.
module gne_gate_unit (
    input  gne_pkg::gate_entry_t        entry,
    input  logic [gne_pkg::MASK_W-1:0]  vals,
    output logic                        result
);
    import gne_pkg::*;

    logic [1:0] arity;
    logic [2:0] idx;
    logic [7:0] tbl;

    always_comb
    begin
        arity  = kind_arity(entry.kind);
        tbl    = kind_table(entry.kind);
        idx[0] = vals[entry.op_a];
        idx[1] = (arity >= 2'd2) ? vals[entry.op_b] : 1'b0;
        idx[2] = (arity == 2'd3) ? vals[entry.op_c] : 1'b0;
        result = tbl[idx];
    end

endmodule

// ===== hdl/gate_netlist_evaluator.sv =====
// Gate netlist evaluator top level. Clear, no-op and a bad start level finish from idle;
// add reads the live mask and writes in the add state if valid; evaluate scans all slots,
// then runs the gates from the start level on. One word at a time, started in idle only.
// Results cannot be stalled. After reset, INIT writes the level-zero mask, busy high.
// Depends on gne_pkg, gne_ram, gne_gate_unit.
module gate_netlist_evaluator #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            bitness_we,
    input  logic [gne_pkg::BITNESS_W-1:0]   bitness,
    input  logic [1:0]                      mode,
    input  logic [gne_pkg::KIND_W-1:0]      gate_kind,
    input  logic [gne_pkg::OP_W-1:0]        operand_a,
    input  logic [gne_pkg::OP_W-1:0]        operand_b,
    input  logic [gne_pkg::OP_W-1:0]        operand_c,
    input  logic [gne_pkg::INBITS_W-1:0]    input_bits,
    input  logic [gne_pkg::COUNT_W-1:0]     start_level,
    output logic                            done,
    output logic [gne_pkg::MASK_W-1:0]      slot_values,
    output logic [1:0]                      status,
    output logic [gne_pkg::COUNT_W-1:0]     gate_count
);
    import gne_pkg::*;

    localparam int SLOT_CAP = (MAX_SLOTS < MASK_W) ? MAX_SLOTS : MASK_W;
    localparam int GA_W     = $clog2(SLOT_CAP);
    localparam int LA_W     = $clog2(SLOT_CAP + 1);
    localparam int SC_W     = $clog2(SLOT_CAP);

    state_t                 state_reg, state_next;
    logic [BITNESS_W-1:0]   bitness_reg;
    logic [COUNT_W-1:0]     gate_total_reg, gate_total_next;
    logic [COUNT_W-1:0]     slot_total_reg, slot_total_next;
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [MASK_W-1:0]      vals_reg, vals_next;
    logic [INBITS_W-1:0]    bits_reg, bits_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [OP_W-1:0]        op_a_reg, op_a_next;
    logic [OP_W-1:0]        op_b_reg, op_b_next;
    logic [OP_W-1:0]        op_c_reg, op_c_next;
    logic [COUNT_W-1:0]     level_reg, level_next;
    logic [COUNT_W-1:0]     g_reg, g_next;
    logic [SC_W-1:0]        slot_cnt_reg, slot_cnt_next;

    logic                   mask_we, mask_re;
    logic [LA_W-1:0]        mask_waddr, mask_raddr;
    logic [MASK_W-1:0]      mask_wdata, mask_rd;
    logic                   gate_we, gate_re;
    logic [GA_W-1:0]        gate_waddr, gate_raddr;
    logic [ENTRY_W-1:0]     gate_wdata, gate_rd;
    logic                   gate_bit;

    logic [COUNT_W-1:0]     clamp_n;
    logic [COUNT_W-1:0]     g_inc;
    logic [COUNT_W-1:0]     out_sum;
    logic [OP_W-1:0]        scan_idx;
    logic [1:0]             add_arity;
    logic                   add_ok;
    logic [MASK_W-1:0]      add_mask;
    gate_entry_t            add_entry;

    gne_ram #(
        .WIDTH (MASK_W),
        .DEPTH (SLOT_CAP + 1)
    ) u_live_mem (
        .clk     (clk),
        .we      (mask_we),
        .wr_addr (mask_waddr),
        .wr_data (mask_wdata),
        .re      (mask_re),
        .rd_addr (mask_raddr),
        .rd_data (mask_rd)
    );

    gne_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_CAP)
    ) u_gate_mem (
        .clk     (clk),
        .we      (gate_we),
        .wr_addr (gate_waddr),
        .wr_data (gate_wdata),
        .re      (gate_re),
        .rd_addr (gate_raddr),
        .rd_data (gate_rd)
    );

    gne_gate_unit u_gate_unit (
        .entry  (gate_entry_t'(gate_rd)),
        .vals   (vals_reg),
        .result (gate_bit)
    );

    always_comb
    begin
        clamp_n = {1'b0, bitness_reg};
        if (clamp_n < COUNT_W'(BITNESS_MIN))
        begin
            clamp_n = COUNT_W'(BITNESS_MIN);
        end
        if (clamp_n > COUNT_W'(BITNESS_MAX))
        begin
            clamp_n = COUNT_W'(BITNESS_MAX);
        end
        if (clamp_n > COUNT_W'(SLOT_CAP))
        begin
            clamp_n = COUNT_W'(SLOT_CAP);
        end
    end

    always_comb
    begin
        add_arity = kind_arity(kind_reg);
        add_ok    = (kind_reg <= KIND_MAJ) && (slot_total_reg < COUNT_W'(SLOT_CAP))
                    && mask_rd[op_a_reg];
        if (add_arity >= 2'd2)
        begin
            add_ok = add_ok && (op_b_reg > op_a_reg) && mask_rd[op_b_reg];
        end
        if (add_arity == 2'd3)
        begin
            add_ok = add_ok && (op_c_reg > op_b_reg) && mask_rd[op_c_reg];
        end
        add_mask = mask_rd;
        add_mask[op_a_reg] = 1'b0;
        if (add_arity >= 2'd2)
        begin
            add_mask[op_b_reg] = 1'b0;
        end
        if (add_arity == 2'd3)
        begin
            add_mask[op_c_reg] = 1'b0;
        end
        add_mask[slot_total_reg[OP_W-1:0]] = 1'b1;
        add_entry.kind = kind_reg;
        add_entry.op_a = op_a_reg;
        add_entry.op_b = op_b_reg;
        add_entry.op_c = op_c_reg;
    end

    assign g_inc    = g_reg + COUNT_W'(1);
    assign out_sum  = slot_total_reg - gate_total_reg + g_reg;
    assign scan_idx = OP_W'(slot_cnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        gate_total_next = gate_total_reg;
        slot_total_next = slot_total_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        vals_next       = vals_reg;
        bits_next       = bits_reg;
        kind_next       = kind_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        op_c_next       = op_c_reg;
        level_next      = level_reg;
        g_next          = g_reg;
        slot_cnt_next   = slot_cnt_reg;
        mask_we         = 1'b0;
        mask_waddr      = '0;
        mask_wdata      = low_ones(clamp_n);
        mask_re         = 1'b0;
        mask_raddr      = '0;
        gate_we         = 1'b0;
        gate_waddr      = gate_total_reg[GA_W-1:0];
        gate_wdata      = add_entry;
        gate_re         = 1'b0;
        gate_raddr      = g_reg[GA_W-1:0];

        unique case (state_reg)
            ST_INIT:
            begin
                mask_we    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next   = gate_kind;
                    op_a_next   = operand_a;
                    op_b_next   = operand_b;
                    op_c_next   = operand_c;
                    vals_next   = '0;
                    status_next = STATUS_OK;
                    unique case (mode_t'(mode))
                        MODE_CLEAR:
                        begin
                            mask_we         = 1'b1;
                            slot_total_next = clamp_n;
                            gate_total_next = '0;
                            done_next       = 1'b1;
                        end
                        MODE_ADD:
                        begin
                            mask_re    = 1'b1;
                            mask_raddr = gate_total_reg[LA_W-1:0];
                            state_next = ST_ADD;
                        end
                        MODE_EVAL:
                        begin
                            if (start_level > gate_total_reg)
                            begin
                                status_next = STATUS_LEVEL;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                mask_re       = 1'b1;
                                mask_raddr    = start_level[LA_W-1:0];
                                bits_next     = input_bits;
                                level_next    = start_level;
                                slot_cnt_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        MODE_NOP:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADD:
            begin
                if (add_ok)
                begin
                    gate_we         = 1'b1;
                    mask_we         = 1'b1;
                    mask_waddr      = LA_W'(gate_total_reg + COUNT_W'(1));
                    mask_wdata      = add_mask;
                    gate_total_next = gate_total_reg + COUNT_W'(1);
                    slot_total_next = slot_total_reg + COUNT_W'(1);
                end
                else
                begin
                    status_next = STATUS_REJECT;
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (mask_rd[scan_idx])
                begin
                    vals_next[scan_idx] = bits_reg[0];
                    bits_next           = bits_reg >> 1;
                end
                slot_cnt_next = slot_cnt_reg + SC_W'(1);
                if (slot_cnt_reg == SC_W'(SLOT_CAP - 1))
                begin
                    if (level_reg == gate_total_reg)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        gate_re    = 1'b1;
                        gate_raddr = level_reg[GA_W-1:0];
                        g_next     = level_reg;
                        state_next = ST_GATES;
                    end
                end
            end
            ST_GATES:
            begin
                vals_next[out_sum[OP_W-1:0]] = gate_bit;
                if (g_inc == gate_total_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    gate_re    = 1'b1;
                    gate_raddr = g_inc[GA_W-1:0];
                    g_next     = g_inc;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            bitness_reg    <= BITNESS_RESET;
            gate_total_reg <= '0;
            slot_total_reg <= COUNT_W'(BITNESS_RESET);
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            gate_total_reg <= gate_total_next;
            slot_total_reg <= slot_total_next;
            done_reg       <= done_next;
            if (bitness_we)
            begin
                bitness_reg <= bitness;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        vals_reg     <= vals_next;
        bits_reg     <= bits_next;
        kind_reg     <= kind_next;
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        op_c_reg     <= op_c_next;
        level_reg    <= level_next;
        g_reg        <= g_next;
        slot_cnt_reg <= slot_cnt_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign slot_values = vals_reg;
    assign status      = status_reg;
    assign gate_count  = gate_total_reg;

endmodule

// ===== sim/tb_gate_netlist_evaluator.sv =====
// Self-checking bench for gate_netlist_evaluator: a directed table, then random netlists.
// Each result is checked against a table value or a model of gates and live-slot masks.
// Depends on gne_pkg and the gate_netlist_evaluator RTL.
module tb_gate_netlist_evaluator;

    import gne_pkg::*;

    localparam int MAX_SLOTS    = 64;
    localparam int SLOT_CAP     = (MAX_SLOTS < MASK_W) ? MAX_SLOTS : MASK_W;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 2 * SLOT_CAP + 8;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DIR_N        = 29;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct packed {
        logic [MASK_W-1:0]  slots;
        status_t            st;
        logic [COUNT_W-1:0] count;
    } outcome_t;

    typedef struct packed {
        bit                  is_cfg;
        mode_t               md;
        logic [KIND_W-1:0]   kind;
        logic [OP_W-1:0]     a;
        logic [OP_W-1:0]     b;
        logic [OP_W-1:0]     c;
        logic [INBITS_W-1:0] bits;
        logic [COUNT_W-1:0]  level;
        bit                  fixed;
        outcome_t            want;
    } step_row_t;

    localparam outcome_t UNTYPED = '0;

    localparam step_row_t DIRECTED_STEPS [DIR_N] = '{
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 7'd0, 1'b1,
          '{64'hFF, STATUS_OK, 7'd0}},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd1, 1'b1,
          '{64'd0, STATUS_LEVEL, 7'd0}},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd127, 1'b1,
          '{64'd0, STATUS_LEVEL, 7'd0}},
        '{1'b0, MODE_ADD, KIND_UNUSED, 6'd63, 6'd63, 6'd63, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd0}},
        '{1'b0, MODE_ADD, KIND_NOT, 6'd8, 6'd0, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd0}},
        '{1'b0, MODE_ADD, KIND_AND, 6'd3, 6'd3, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd0}},
        '{1'b0, MODE_ADD, KIND_AND, 6'd5, 6'd2, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd0}},
        '{1'b0, MODE_ADD, KIND_NOT, 6'd0, 6'd63, 6'd63, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_OK, 7'd1}},
        '{1'b0, MODE_ADD, KIND_AND, 6'd1, 6'd2, 6'd63, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_OK, 7'd2}},
        '{1'b0, MODE_ADD, KIND_OR, 6'd0, 6'd3, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd2}},
        '{1'b0, MODE_ADD, KIND_OR, 6'd3, 6'd4, 6'd0, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADD, KIND_XOR, 6'd5, 6'd6, 6'd0, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADD, KIND_NAND, 6'd7, 6'd8, 6'd0, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADD, KIND_NOR, 6'd9, 6'd10, 6'd0, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADD, KIND_MAJ, 6'd11, 6'd12, 6'd13, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_ADD, KIND_MAJ, 6'd12, 6'd13, 6'd14, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_REJECT, 7'd7}},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'hA5A5_A5A5, 7'd3, 1'b0, UNTYPED},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h1, 7'd7, 1'b0, UNTYPED},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd8, 1'b1,
          '{64'd0, STATUS_LEVEL, 7'd7}},
        '{1'b0, MODE_NOP, KIND_UNUSED, 6'd63, 6'd63, 6'd63, 32'hFFFF_FFFF, 7'd127, 1'b1,
          '{64'd0, STATUS_OK, 7'd7}},
        '{1'b0, MODE_CLEAR, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_OK, 7'd0}},
        '{1'b1, MODE_NOP, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'd0, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_CLEAR, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_OK, 7'd0}},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 7'd0, 1'b1,
          '{64'h3, STATUS_OK, 7'd0}},
        '{1'b1, MODE_NOP, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'd63, 7'd0, 1'b0, UNTYPED},
        '{1'b0, MODE_CLEAR, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'h0, 7'd0, 1'b1,
          '{64'd0, STATUS_OK, 7'd0}},
        '{1'b0, MODE_EVAL, KIND_NOT, 6'd0, 6'd0, 6'd0, 32'hFFFF_FFFF, 7'd0, 1'b1,
          '{64'h0000_0000_FFFF_FFFF, STATUS_OK, 7'd0}}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  bitness_we  = 1'b0;
    logic [BITNESS_W-1:0]  bitness     = '0;
    logic [1:0]            mode        = '0;
    logic [KIND_W-1:0]     gate_kind   = '0;
    logic [OP_W-1:0]       operand_a   = '0;
    logic [OP_W-1:0]       operand_b   = '0;
    logic [OP_W-1:0]       operand_c   = '0;
    logic [INBITS_W-1:0]   input_bits  = '0;
    logic [COUNT_W-1:0]    start_level = '0;
    logic                  done;
    logic [MASK_W-1:0]     slot_values;
    logic [1:0]            status;
    logic [COUNT_W-1:0]    gate_count;

    logic [BITNESS_W-1:0]  bitness_shadow;
    gate_entry_t           gate_list [64];
    logic [MASK_W-1:0]     live_by_level [65];
    int                    gates_placed;
    int                    slots_used;

    outcome_t              awaited_outcomes [$];
    outcome_t              oldest;
    int                    mismatches  = 0;
    int                    cycle_count = 0;
    int                    items_sent  = 0;

    gate_netlist_evaluator #(
        .MAX_SLOTS(MAX_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .bitness_we(bitness_we),
        .bitness(bitness),
        .mode(mode),
        .gate_kind(gate_kind),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .operand_c(operand_c),
        .input_bits(input_bits),
        .start_level(start_level),
        .done(done),
        .slot_values(slot_values),
        .status(status),
        .gate_count(gate_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gate_arity(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_AND, KIND_OR, KIND_XOR, KIND_NAND, KIND_NOR: return 2;
            KIND_MAJ: return 3;
            default:  return 1;
        endcase
    endfunction

    function automatic logic [7:0] gate_truth(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_AND:  return 8'b1000;
            KIND_OR:   return 8'b1110;
            KIND_XOR:  return 8'b0110;
            KIND_NAND: return 8'b0111;
            KIND_NOR:  return 8'b0001;
            KIND_MAJ:  return 8'b1110_1000;
            default:   return 8'b01;
        endcase
    endfunction

    function automatic void restart_netlist();
        int n;
        n = int'(bitness_shadow);
        if (n < BITNESS_MIN)
            n = BITNESS_MIN;
        if (n > BITNESS_MAX)
            n = BITNESS_MAX;
        if (n > SLOT_CAP)
            n = SLOT_CAP;
        slots_used = n;
        gates_placed = 0;
        live_by_level[0] = '0;
        for (int s = 0; s < n; s++)
            live_by_level[0][s] = 1'b1;
    endfunction

    function automatic status_t place_gate(input logic [KIND_W-1:0] kind,
                                           input logic [OP_W-1:0] a,
                                           input logic [OP_W-1:0] b,
                                           input logic [OP_W-1:0] c);
        logic [OP_W-1:0]   ops [3];
        logic [MASK_W-1:0] m;
        int                n;
        ops = '{a, b, c};
        if (kind > KIND_MAJ)
            return STATUS_REJECT;
        if (slots_used >= SLOT_CAP || gates_placed >= 64)
            return STATUS_REJECT;
        n = gate_arity(kind);
        m = live_by_level[gates_placed];
        for (int k = 0; k < n; k++)
        begin
            if (k > 0 && ops[k] <= ops[k-1])
                return STATUS_REJECT;
            if (!m[ops[k]])
                return STATUS_REJECT;
        end
        for (int k = 0; k < n; k++)
            m[ops[k]] = 1'b0;
        m[slots_used[5:0]] = 1'b1;
        gate_list[gates_placed] = {c, b, a, kind};
        gates_placed++;
        live_by_level[gates_placed] = m;
        slots_used++;
        return STATUS_OK;
    endfunction

    function automatic logic [MASK_W-1:0] run_gates(input logic [INBITS_W-1:0] bits,
                                                    input int level);
        logic [MASK_W-1:0]   v;
        logic [MASK_W-1:0]   m;
        logic [INBITS_W-1:0] rest;
        gate_entry_t         e;
        logic [KIND_W-1:0]   kind;
        logic [OP_W-1:0]     ops [3];
        logic [2:0]          idx;
        logic [7:0]          truth;
        logic [OP_W-1:0]     dest;
        int                  first_out;
        v = '0;
        m = live_by_level[level];
        rest = bits;
        for (int s = 0; s < MASK_W; s++)
        begin
            if (m[s])
            begin
                v[s] = rest[0];
                rest = rest >> 1;
            end
        end
        first_out = slots_used - gates_placed;
        for (int g = level; g < gates_placed; g++)
        begin
            e = gate_list[g];
            kind = e.kind;
            if (kind > KIND_MAJ)
                kind = KIND_NOT;
            ops = '{e.op_a, e.op_b, e.op_c};
            idx = '0;
            for (int k = 0; k < gate_arity(kind); k++)
                idx[k] = v[ops[k]];
            dest = OP_W'(first_out + g);
            truth = gate_truth(kind);
            v[dest] = truth[idx];
        end
        return v;
    endfunction

    function automatic outcome_t netlist_outcome(input step_row_t r);
        outcome_t o;
        o = '0;
        o.st = STATUS_OK;
        case (r.md)
            MODE_CLEAR: restart_netlist();
            MODE_ADD:   o.st = place_gate(r.kind, r.a, r.b, r.c);
            MODE_EVAL:
            begin
                if (r.level > gates_placed)
                    o.st = STATUS_LEVEL;
                else
                    o.slots = run_gates(r.bits, r.level);
            end
            default: ;
        endcase
        o.count = COUNT_W'(gates_placed);
        return o;
    endfunction

    task automatic issue_word(input step_row_t r);
        outcome_t predicted;
        outcome_t queued;
        mode        <= r.md;
        gate_kind   <= r.kind;
        operand_a   <= r.a;
        operand_b   <= r.b;
        operand_c   <= r.c;
        input_bits  <= r.bits;
        start_level <= r.level;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = netlist_outcome(r);
        queued = r.fixed ? r.want : predicted;
        awaited_outcomes.insert(awaited_outcomes.size(), queued);
    endtask

    task automatic pause(input bit quiet);
        int pick;
        int gap;
        pick = $urandom_range(99);
        if (quiet || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(3, 1);
        else if (pick < 98)
            gap = $urandom_range(40, 8);
        else
            gap = $urandom_range(150, 41);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_bitness(input logic [BITNESS_W-1:0] value);
        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_outcomes.size() != 0 || busy !== 1'b0);
        bitness_we <= 1'b1;
        bitness    <= value;
        @(posedge clk);
        bitness_we <= 1'b0;
        bitness_shadow = value;
    endtask

    task automatic random_phase(input logic [BITNESS_W-1:0] cfg, input int len);
        step_row_t         r;
        bit                quiet;
        logic [MASK_W-1:0] m;
        logic [OP_W-1:0]   ops [3];
        logic [OP_W-1:0]   t;
        int                pick;
        int                avail;
        int                need;
        int                k;
        int                arity;
        write_bitness(cfg);
        quiet = ($urandom_range(3) == 0);
        r = '0;
        r.md = MODE_CLEAR;
        r.bits = $urandom;
        issue_word(r);
        pause(quiet);
        items_sent++;
        for (int i = 0; i < len; i++)
        begin
            r.kind  = KIND_W'($urandom_range(7));
            r.a     = OP_W'($urandom_range(63));
            r.b     = OP_W'($urandom_range(63));
            r.c     = OP_W'($urandom_range(63));
            r.bits  = $urandom;
            r.level = COUNT_W'($urandom_range(127));
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                r.md = MODE_ADD;
                if ($urandom_range(99) < 88)
                begin
                    r.kind = KIND_W'($urandom_range(6));
                    arity = gate_arity(r.kind);
                    m = live_by_level[gates_placed];
                    avail = $countones(m);
                    if (avail < arity)
                    begin
                        r.kind = KIND_NOT;
                        arity = 1;
                    end
                    ops = '{r.a, r.b, r.c};
                    need = arity;
                    k = 0;
                    for (int s = 0; s < MASK_W && need > 0; s++)
                    begin
                        if (m[s])
                        begin
                            if ($urandom_range(avail - 1) < need)
                            begin
                                ops[k] = OP_W'(s);
                                k++;
                                need--;
                            end
                            avail--;
                        end
                    end
                    // break the ordering now and then
                    if (arity > 1 && $urandom_range(99) < 10)
                    begin
                        t = ops[0];
                        ops[0] = ops[arity-1];
                        ops[arity-1] = t;
                    end
                    r.a = ops[0];
                    r.b = ops[1];
                    r.c = ops[2];
                end
            end
            else if (pick < 92)
            begin
                r.md = MODE_EVAL;
                if ($urandom_range(99) < 88)
                    r.level = COUNT_W'($urandom_range(gates_placed));
                else
                    r.level = COUNT_W'($urandom_range(127, gates_placed + 1));
            end
            else if (pick < 96)
                r.md = MODE_NOP;
            else
                r.md = MODE_CLEAR;
            issue_word(r);
            pause(quiet);
            if (r.md != MODE_NOP)
                items_sent++;
        end
    endtask

    always @(posedge clk)
    begin
        if (done === 1'b1)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $error("result word with nothing pending");
                mismatches++;
            end
            else
            begin
                oldest = awaited_outcomes.pop_front();
                if (slot_values !== oldest.slots)
                begin
                    $error("slot_values: expected %h, got %h", oldest.slots, slot_values);
                    mismatches++;
                end
                if (status !== oldest.st)
                begin
                    $error("status: expected %0d, got %0d", oldest.st, status);
                    mismatches++;
                end
                if (gate_count !== oldest.count)
                begin
                    $error("gate_count: expected %0d, got %0d", oldest.count, gate_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int phase;
        logic [BITNESS_W-1:0] cfg;
        bitness_shadow = BITNESS_RESET;
        restart_netlist();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
        begin
            if (DIRECTED_STEPS[i].is_cfg)
                write_bitness(DIRECTED_STEPS[i].bits[BITNESS_W-1:0]);
            else
            begin
                issue_word(DIRECTED_STEPS[i]);
                pause(1'b0);
            end
        end

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:       cfg = 6'd2;
                1:       cfg = 6'd32;
                2:       cfg = 6'd1;
                3:       cfg = 6'd0;
                4:       cfg = 6'd33;
                default: cfg = BITNESS_W'($urandom_range(63));
            endcase
            random_phase(cfg, $urandom_range(150, 30));
            phase++;
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_outcomes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
